@@ hw/rtl/tmpt_pkg.sv @@
`default_nettype none

package tmpt_pkg;

  localparam int unsigned RING_DEPTH = 36;
  localparam int unsigned AVG_SHIFT  = 5;

  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned COEF_W    = 24;
  localparam int unsigned CFG_W     = COEF_W;
  localparam int unsigned SLOT_W    = $clog2(RING_DEPTH);
  // sum of the whole ring never overflows this width
  localparam int unsigned SUM_W     = PERIOD_W + $clog2(RING_DEPTH);
  localparam int unsigned DIV_CNT_W = $clog2(COEF_W);

  localparam logic [PERIOD_W-1:0] PERIOD_STOPPED   = '1;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = PERIOD_W'(1380);
  localparam logic [COEF_W-1:0]   COEF_RESET       = COEF_W'(7500000);

  typedef enum logic [1:0] {
    OP_CAPTURE  = 2'd0,
    OP_OVERFLOW = 2'd1,
    OP_REQUEST  = 2'd2
  } op_e;

  typedef enum logic {
    REG_MIN_PERIOD = 1'b0,
    REG_RPM_COEF   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic capture;
    logic overflow;
    logic scan_start;
    logic scan_rd;
    logic trim;
    logic prep;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/trimmed_mean_period_tachometer_unit.sv @@
// Tooth-period tachometer, one channel, trimmed-mean average.
// Input channel (in_valid_i/in_ready_o) carries op_i and period_i:
//   capture  - period_i is stored in a 36-entry ring if above min_period
//   overflow - every ring entry reads as 65535 (shaft stopped)
//   request  - one rpm result on the output channel (out_valid_o/out_ready_i)
// Capture and overflow do not close the input; in_ready_o stays high after them.
// A request reads all 36 ring entries through the single memory read port,
// then trims the extremes and forms the average, runs the bit-serial divider
// and loads the output register. in_ready_o is low
// from the request transfer until the result is loaded.
// The result sits in an output register; new items are taken while it waits.
// If the receiver stalls and a second request finishes, the block holds in
// its last step until the register frees.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once:
// index 0 min_period, index 1 rpm_coefficient.
// Reset: ring reads 65535 everywhere, write slot 0, registers at defaults,
// no result pending.
`default_nettype none

module trimmed_mean_period_tachometer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [tmpt_pkg::PERIOD_W-1:0] period_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tmpt_pkg::PERIOD_W-1:0]      rpm_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [tmpt_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import tmpt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tmpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tmpt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .period_i    (period_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rpm_o       (rpm_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/tmpt_ctrl.sv @@
`default_nettype none

module tmpt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    op_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tmpt_pkg::cmd_t     cmd_o,
  input  wire tmpt_pkg::sts_t sts_i
);
  import tmpt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_TRIM,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   in_xfer;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (op_i)
            OP_CAPTURE:  cmd_o.capture = 1'b1;
            OP_OVERFLOW: cmd_o.overflow = 1'b1;
            OP_REQUEST: begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      // last read word is folded in during this cycle
      ST_DRAIN: state_d = ST_TRIM;
      ST_TRIM: begin
        cmd_o.trim = 1'b1;
        state_d    = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tmpt_dp.sv @@
`default_nettype none

module tmpt_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [tmpt_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic [tmpt_pkg::PERIOD_W-1:0] period_i,
  input  wire tmpt_pkg::cmd_t                cmd_i,
  output tmpt_pkg::sts_t                     sts_o,
  output logic [tmpt_pkg::PERIOD_W-1:0]      rpm_o
);
  import tmpt_pkg::*;

  logic [PERIOD_W-1:0] min_period_q;
  logic [COEF_W-1:0]   coef_q;

  logic [PERIOD_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [SLOT_W-1:0]   wr_slot_q;
  logic                wr_en;

  logic [SLOT_W-1:0]   scan_addr_q;
  logic                rd_vld_q;
  logic                rd_hit_q;
  logic [PERIOD_W-1:0] rd_data_q;
  logic [PERIOD_W-1:0] v;

  logic [SUM_W-1:0]    sum_q;
  logic [PERIOD_W-1:0] hi1_q, hi2_q, lo1_q, lo2_q;
  logic [SUM_W-1:0]    extremes;
  logic [SUM_W-1:0]    avg;
  logic                avg_bad;

  logic [COEF_W-1:0]    dvd_q;
  logic [PERIOD_W-1:0]  dvs_q;
  logic [PERIOD_W-1:0]  rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [PERIOD_W:0]    trial;
  logic                 q_bit;
  logic [PERIOD_W-1:0]  rpm_q;

  function automatic logic [SLOT_W-1:0] sts_wrap(input logic [SLOT_W-1:0] s);
    sts_wrap = (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  assign wr_en = cmd_i.capture && (period_i > min_period_q);

  // entries without a valid bit read as a stopped shaft
  assign v = rd_hit_q ? rd_data_q : PERIOD_STOPPED;

  assign extremes = SUM_W'(hi1_q) + SUM_W'(hi2_q) + SUM_W'(lo1_q) + SUM_W'(lo2_q);
  assign avg      = sum_q >> AVG_SHIFT;
  assign avg_bad  = (avg == '0) || (avg >= SUM_W'(PERIOD_STOPPED));

  assign trial = {rem_q, dvd_q[COEF_W-1]};
  assign q_bit = (trial >= {1'b0, dvs_q});

  assign sts_o.scan_last = (scan_addr_q == SLOT_W'(RING_DEPTH - 1));
  assign sts_o.div_last  = (div_cnt_q == DIV_CNT_W'(COEF_W - 1));
  assign rpm_o           = rpm_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) ring_mem[wr_slot_q] <= period_i;
    if (cmd_i.scan_rd) begin
      rd_data_q <= ring_mem[scan_addr_q];
      rd_hit_q  <= ring_vld_q[scan_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q <= MIN_PERIOD_RESET;
      coef_q       <= COEF_RESET;
      ring_vld_q   <= '0;
      wr_slot_q    <= '0;
      scan_addr_q  <= '0;
      rd_vld_q     <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MIN_PERIOD: min_period_q <= cfg_wdata_i[PERIOD_W-1:0];
          REG_RPM_COEF:   coef_q       <= cfg_wdata_i[COEF_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.overflow) begin
        ring_vld_q <= '0;
      end else if (wr_en) begin
        ring_vld_q[wr_slot_q] <= 1'b1;
        wr_slot_q <= sts_wrap(wr_slot_q);
      end
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
      end else if (cmd_i.scan_rd && !sts_o.scan_last) begin
        scan_addr_q <= scan_addr_q + SLOT_W'(1);
      end
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.prep) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      sum_q <= '0;
      hi1_q <= '0;
      hi2_q <= '0;
      lo1_q <= '1;
      lo2_q <= '1;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(v);
      if (v > hi1_q) begin
        hi2_q <= hi1_q;
        hi1_q <= v;
      end else if (v > hi2_q) begin
        hi2_q <= v;
      end
      if (v < lo1_q) begin
        lo2_q <= lo1_q;
        lo1_q <= v;
      end else if (v < lo2_q) begin
        lo2_q <= v;
      end
    end else if (cmd_i.trim) begin
      sum_q <= sum_q - extremes;
    end

    // restoring divide, one quotient bit per cycle
    if (cmd_i.prep) begin
      rem_q <= '0;
      if (avg_bad) begin
        dvd_q <= '0;
        dvs_q <= PERIOD_W'(1);
      end else begin
        dvd_q <= coef_q;
        dvs_q <= avg[PERIOD_W-1:0];
      end
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? PERIOD_W'(trial - {1'b0, dvs_q}) : trial[PERIOD_W-1:0];
      dvd_q <= {dvd_q[COEF_W-2:0], q_bit};
    end

    if (cmd_i.load_out) begin
      rpm_q <= (|dvd_q[COEF_W-1:PERIOD_W]) ? PERIOD_STOPPED : dvd_q[PERIOD_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tmpt_checker.sv @@
`default_nettype none

module tmpt_sva (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [1:0]                    op_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [tmpt_pkg::PERIOD_W-1:0] rpm_o
);
  import tmpt_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rpm_o))
    else $error("result changed while stalled");

  // a request transfer closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_REQUEST) |=> !in_ready_o)
    else $error("input open right after request transfer");

  // captures and overflows leave the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i != OP_REQUEST) |=> in_ready_o)
    else $error("input closed after non-request transfer");

  // a result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a request in flight");

endmodule

bind trimmed_mean_period_tachometer_unit tmpt_sva u_tmpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .rpm_o       (rpm_o)
);

`default_nettype wire
